/* sv/midi_note_ownership_tracker_assert.svh */
// assertion macros shared by the note tracker rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef MIDI_NOTE_OWNERSHIP_TRACKER_ASSERT_SVH
`define MIDI_NOTE_OWNERSHIP_TRACKER_ASSERT_SVH

// checked only while out of reset
`define MNOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define MNOT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/mnot_pkg.sv */
// types and constants of the midi note ownership tracker
// no dependencies
`default_nettype none

package mnot_pkg;

  // frame slots at or beyond this limit are never played
  localparam logic [12:0] FRAME_LIMIT = 13'd1024;

  // operation selector of an input word
  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_PLAY  = 1'b1
  } op_e;

  // message kind
  typedef enum logic [1:0] {
    KIND_OFF   = 2'd0,
    KIND_ON    = 2'd1,
    KIND_OTHER = 2'd2
  } kind_e;

  // back end sequencer
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e        op;
    kind_e      kind;
    logic [3:0] chan;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [5:0] source;
    logic       mask_hit;
    logic       play_go;
  } queue_entry_t;

  // stored fields of one note
  typedef struct packed {
    logic [5:0] owner;
    logic [3:0] chan;
  } note_entry_t;

  // one result word
  typedef struct packed {
    logic       accepted;
    logic       emit_valid;
    kind_e      emit_kind;
    logic [3:0] emit_channel;
    logic [6:0] emit_note;
    logic [6:0] emit_velocity;
    logic       consumed;
  } result_t;

endpackage

`default_nettype wire

/* sv/mnot_front.sv */
// front end: accepts input words, holds the source mask, classifies each word
// depends on mnot_pkg
`default_nettype none

module mnot_front #(
  parameter int unsigned SOURCE_COUNT = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [63:0]          cfg_wdata_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [47:0]          s_axis_tdata_i,
  input  wire logic [2:0]           s_axis_tuser_i,
  input  wire logic                 queue_full_i,
  output logic                      push_o,
  output mnot_pkg::queue_entry_t    entry_o
);

  logic [SOURCE_COUNT-1:0] mask_q;
  logic [63:0]             mask_ext;
  logic [5:0]              source;
  logic [9:0]              message_frame;
  logic [9:0]              frame_index;

  // accept source mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i[SOURCE_COUNT-1:0];
    end
  end

  assign source        = s_axis_tdata_i[23:18];
  assign message_frame = s_axis_tdata_i[33:24];
  assign frame_index   = s_axis_tdata_i[43:34];
  assign mask_ext      = 64'(mask_q);

  // handshake with the queue
  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;

  // classify the word
  always_comb begin
    entry_o.op       = s_axis_tuser_i[0] ? mnot_pkg::OP_PLAY : mnot_pkg::OP_OFFER;
    case (s_axis_tuser_i[2:1])
      mnot_pkg::KIND_OFF: entry_o.kind = mnot_pkg::KIND_OFF;
      mnot_pkg::KIND_ON:  entry_o.kind = mnot_pkg::KIND_ON;
      default:            entry_o.kind = mnot_pkg::KIND_OTHER;
    endcase
    entry_o.chan     = s_axis_tdata_i[3:0];
    entry_o.note     = s_axis_tdata_i[10:4];
    entry_o.velocity = s_axis_tdata_i[17:11];
    entry_o.source   = source;
    // sources beyond the count never pass by mask
    entry_o.mask_hit = (7'(source) < 7'(SOURCE_COUNT)) && mask_ext[source];
    // slot within limit and message not scheduled ahead of it
    entry_o.play_go  = ({3'b000, frame_index} < mnot_pkg::FRAME_LIMIT) &&
                       (message_frame <= frame_index);
  end

endmodule

`default_nettype wire

/* sv/mnot_queue.sv */
// two-entry queue between the front end and the back end
// depends on mnot_pkg and the assertion macro header
`default_nettype none

`include "midi_note_ownership_tracker_assert.svh"

module mnot_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire mnot_pkg::queue_entry_t entry_i,
  output logic                        full_o,
  input  wire logic                   pop_i,
  output logic                        empty_o,
  output mnot_pkg::queue_entry_t      head_o
);

  mnot_pkg::queue_entry_t slot_q [2];
  logic                   wr_ptr_q;
  logic                   rd_ptr_q;
  logic [1:0]             count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  `MNOT_ASSERT(a_queue_grow, (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1), "queue count did not grow on push")
  `MNOT_ASSERT(a_queue_shrink, (pop_i && !push_i) |=> (count_q == $past(count_q) - 2'd1), "queue count did not shrink on pop")
  `MNOT_ASSERT(a_queue_pop_empty, pop_i |-> (count_q != 2'd0), "pop from empty queue")

endmodule

`default_nettype wire

/* sv/mnot_back.sv */
// back end: note table, play and offer execution, output register
// depends on mnot_pkg and the assertion macro header
`default_nettype none

`include "midi_note_ownership_tracker_assert.svh"

module mnot_back #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   empty_i,
  input  wire mnot_pkg::queue_entry_t head_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output mnot_pkg::result_t           result_o
);

  localparam int unsigned NW = $clog2(NOTE_COUNT);

  mnot_pkg::back_state_e  state_q, state_d;
  mnot_pkg::queue_entry_t work_q;
  mnot_pkg::note_entry_t  mem_q [NOTE_COUNT];
  mnot_pkg::note_entry_t  rd_q;
  mnot_pkg::note_entry_t  wr_entry;
  mnot_pkg::result_t      res_d;
  mnot_pkg::result_t      out_q;
  logic [NOTE_COUNT-1:0]  active_q;
  logic                   out_valid_q;
  logic                   exec_fire;
  logic                   active;
  logic                   clr_active;
  logic                   set_active;
  logic [NW-1:0]          head_idx;
  logic [NW-1:0]          work_idx;

  assign head_idx = NW'(head_i.note);
  assign work_idx = NW'(work_q.note);
  assign active   = active_q[work_idx];

  // sequencer: read the table, then execute and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnot_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    exec_fire = 1'b0;
    case (state_q)
      mnot_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = mnot_pkg::BK_EXEC;
        end
      end
      mnot_pkg::BK_EXEC: begin
        if (!out_valid_q || m_axis_tready_i) begin
          exec_fire = 1'b1;
          state_d   = mnot_pkg::BK_IDLE;
        end
      end
      default: state_d = mnot_pkg::BK_IDLE;
    endcase
  end

  // working word
  always_ff @(posedge clk_i) begin
    if (pop_o) work_q <= head_i;
  end

  // note table memory, registered read
  always_ff @(posedge clk_i) begin
    if (pop_o) rd_q <= mem_q[head_idx];
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire && set_active) mem_q[work_idx] <= wr_entry;
  end

  assign wr_entry.owner = work_q.source;
  assign wr_entry.chan  = work_q.chan;

  // sounding bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (exec_fire) begin
      if (set_active) begin
        active_q[work_idx] <= 1'b1;
      end else if (clr_active) begin
        active_q[work_idx] <= 1'b0;
      end
    end
  end

  // result and table update
  always_comb begin
    res_d      = '0;
    set_active = 1'b0;
    clr_active = 1'b0;
    if (work_q.op == mnot_pkg::OP_OFFER) begin
      res_d.accepted = work_q.mask_hit ||
                       (work_q.kind == mnot_pkg::KIND_OFF && active &&
                        rd_q.owner == work_q.source);
    end else if (work_q.play_go) begin
      res_d.emit_note = work_q.note;
      case (work_q.kind)
        mnot_pkg::KIND_OFF: begin
          if (active) begin
            clr_active          = 1'b1;
            res_d.emit_valid    = 1'b1;
            res_d.emit_kind     = mnot_pkg::KIND_OFF;
            res_d.emit_channel  = work_q.chan;
            res_d.emit_velocity = work_q.velocity;
          end else begin
            res_d.emit_note = '0;
          end
          res_d.consumed = 1'b1;
        end
        mnot_pkg::KIND_ON: begin
          res_d.emit_valid = 1'b1;
          if (active) begin
            // retrigger: silence the old note first, keep the head
            clr_active          = 1'b1;
            res_d.emit_kind     = mnot_pkg::KIND_OFF;
            res_d.emit_channel  = rd_q.chan;
            res_d.emit_velocity = '0;
            res_d.consumed      = 1'b0;
          end else begin
            set_active          = 1'b1;
            res_d.emit_kind     = mnot_pkg::KIND_ON;
            res_d.emit_channel  = work_q.chan;
            res_d.emit_velocity = work_q.velocity;
            res_d.consumed      = 1'b1;
          end
        end
        default: begin
          res_d.emit_valid    = 1'b1;
          res_d.emit_kind     = mnot_pkg::KIND_OTHER;
          res_d.emit_channel  = work_q.chan;
          res_d.emit_velocity = work_q.velocity;
          res_d.consumed      = 1'b1;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) out_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign result_o        = out_q;

  `MNOT_ASSERT_ALWAYS(a_back_reset, !rst_ni |=> (!out_valid_q && state_q == mnot_pkg::BK_IDLE), "back end not empty in reset")
  `MNOT_ASSERT(a_back_retrigger, (exec_fire && res_d.emit_valid && !res_d.consumed) |-> (res_d.emit_kind == mnot_pkg::KIND_OFF && res_d.emit_velocity == 7'd0), "kept head without inserted note off")
  `MNOT_ASSERT(a_back_note_on, (exec_fire && set_active) |=> active_q[$past(work_idx)], "note on not recorded")

endmodule

`default_nettype wire

/* sv/midi_note_ownership_tracker.sv */
// an accepted word waits in the queue, is popped with a registered note table read,
//   then is executed and its result word registered at the output
// the back end pops the next word only after the last one has executed; its pace is set
//   by the note table's registered read followed by its write-back in the back end
// a two-word queue decouples the input from the table; a stalled output holds one word
// reset: source mask zero, all notes silent, queue and output empty; no clearing pass
`default_nettype none

module midi_note_ownership_tracker #(
  parameter int unsigned NOTE_COUNT   = 128,
  parameter int unsigned SOURCE_COUNT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: accept source mask
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  // input words
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // chan, note, velocity, source, message_frame, frame_index, zero fill
  input  wire logic [47:0] s_axis_tdata_i,
  // operation, kind
  input  wire logic [2:0]  s_axis_tuser_i,
  // result words
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // accepted, emit_valid, emit_channel, emit_note, emit_velocity, consumed, zero fill
  output logic [23:0]      m_axis_tdata_o,
  // emit_kind
  output logic [1:0]       m_axis_tuser_o
);

  mnot_pkg::queue_entry_t entry;
  mnot_pkg::queue_entry_t head;
  mnot_pkg::result_t      result;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;

  // accept and classify
  mnot_front #(
    .SOURCE_COUNT(SOURCE_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .queue_full_i   (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  // decoupling queue
  mnot_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  // table and execution
  mnot_back #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .result_o       (result)
  );

  // pack the result word
  assign m_axis_tdata_o = {3'b000, result.consumed, result.emit_velocity, result.emit_note,
                           result.emit_channel, result.emit_valid, result.accepted};
  assign m_axis_tuser_o = result.emit_kind;

endmodule

`default_nettype wire

/* dv/tracker_result_checker.sv */
// result checker for the midi note ownership tracker: predicts every result word
// from the accepted input words and compares; depends on mnot_pkg
`timescale 1ns / 1ps

module tracker_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // chan, note, velocity, source, message_frame, frame_index, zero fill
  input  logic [47:0] s_axis_tdata_i,
  // operation, kind
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // accepted, emit_valid, emit_channel, emit_note, emit_velocity, consumed, zero fill
  input  logic [23:0] m_axis_tdata_i,
  // emit_kind
  input  logic [1:0]  m_axis_tuser_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  localparam int NOTES         = 128;
  localparam int REPORT_MAX    = 10;
  localparam int PENDING_DEPTH = 64;

  // shadow of the block's mask and note table
  logic [63:0]       mask_shadow;
  logic              note_sounding [NOTES];
  logic [5:0]        note_source [NOTES];
  logic [3:0]        note_chan [NOTES];
  // ring of predicted words still to come
  mnot_pkg::result_t awaited_words [PENDING_DEPTH];
  logic [5:0]        pend_wr;
  logic [5:0]        pend_rd;
  int                pend_count;

  // filter decision or play outcome of one input word, updating the note table
  function automatic mnot_pkg::result_t track_note_word(input logic [47:0] data,
                                                        input logic [2:0] user);
    mnot_pkg::result_t res;
    logic [1:0]        kind_bits;
    logic [3:0]        chan;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [5:0]        src;
    logic [9:0]        mframe;
    logic [9:0]        fidx;
    res       = '0;
    kind_bits = user[2:1];
    chan      = data[3:0];
    note      = data[10:4];
    vel       = data[17:11];
    src       = data[23:18];
    mframe    = data[33:24];
    fidx      = data[43:34];
    // offer: mask hit, or note-off from the owner of a sounding note
    if (user[0] == mnot_pkg::OP_OFFER) begin
      res.accepted = mask_shadow[src] ||
                     (kind_bits == mnot_pkg::KIND_OFF && note_sounding[note] &&
                      note_source[note] == src);
      return res;
    end
    // message still ahead of the slot, or slot out of range
    if ({3'b000, fidx} >= mnot_pkg::FRAME_LIMIT || mframe > fidx) return res;
    if (kind_bits == mnot_pkg::KIND_OFF) begin
      if (note_sounding[note]) begin
        note_sounding[note] = 1'b0;
        res.emit_valid      = 1'b1;
        res.emit_kind       = mnot_pkg::KIND_OFF;
        res.emit_channel    = chan;
        res.emit_note       = note;
        res.emit_velocity   = vel;
      end
      res.consumed = 1'b1;
    end else if (kind_bits == mnot_pkg::KIND_ON) begin
      res.emit_valid = 1'b1;
      res.emit_note  = note;
      if (note_sounding[note]) begin
        // retrigger: silence the old note on its own channel, keep the head
        note_sounding[note] = 1'b0;
        res.emit_kind       = mnot_pkg::KIND_OFF;
        res.emit_channel    = note_chan[note];
        res.emit_velocity   = '0;
      end else begin
        note_sounding[note] = 1'b1;
        note_source[note]   = src;
        note_chan[note]     = chan;
        res.emit_kind       = mnot_pkg::KIND_ON;
        res.emit_channel    = chan;
        res.emit_velocity   = vel;
        res.consumed        = 1'b1;
      end
    end else begin
      // other messages and the unknown kind pass through as other
      res.emit_valid    = 1'b1;
      res.emit_kind     = mnot_pkg::KIND_OTHER;
      res.emit_channel  = chan;
      res.emit_note     = note;
      res.emit_velocity = vel;
      res.consumed      = 1'b1;
    end
    return res;
  endfunction

  // compare result words first, then queue the prediction of the input word
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    mnot_pkg::result_t want;
    mnot_pkg::result_t got;
    if (!rst_ni) begin
      mask_shadow = '0;
      for (int i = 0; i < NOTES; i++) begin
        note_sounding[i] = 1'b0;
        note_source[i]   = '0;
        note_chan[i]     = '0;
      end
      pend_wr          = '0;
      pend_rd          = '0;
      pend_count       = 0;
      mismatch_count_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.accepted      = m_axis_tdata_i[0];
        got.emit_valid    = m_axis_tdata_i[1];
        got.emit_channel  = m_axis_tdata_i[5:2];
        got.emit_note     = m_axis_tdata_i[12:6];
        got.emit_velocity = m_axis_tdata_i[19:13];
        got.consumed      = m_axis_tdata_i[20];
        got.emit_kind     = mnot_pkg::kind_e'(m_axis_tuser_i);
        if (pend_count == 0) begin
          if (mismatch_count_o < REPORT_MAX)
            $display("%0t: result word with nothing expected: tdata %h tuser %h",
                     $time, m_axis_tdata_i, m_axis_tuser_i);
          mismatch_count_o++;
        end else begin
          want       = awaited_words[pend_rd];
          pend_rd    = pend_rd + 6'd1;
          pend_count = pend_count - 1;
          if (got !== want) begin
            if (mismatch_count_o < REPORT_MAX) begin
              $display("%0t: mismatch acc/vld/kind/ch/note/vel/cons expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                       $time, want.accepted, want.emit_valid, want.emit_kind,
                       want.emit_channel, want.emit_note, want.emit_velocity, want.consumed);
              $display("%0t: mismatch acc/vld/kind/ch/note/vel/cons got %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                       $time, got.accepted, got.emit_valid, got.emit_kind,
                       got.emit_channel, got.emit_note, got.emit_velocity, got.consumed);
            end
            mismatch_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        awaited_words[pend_wr] = track_note_word(s_axis_tdata_i, s_axis_tuser_i);
        pend_wr    = pend_wr + 6'd1;
        pend_count = pend_count + 1;
      end
      if (cfg_we_i) mask_shadow = cfg_wdata_i;
    end
    outstanding_o = pend_count;
  end

endmodule

/* dv/tb_midi_note_ownership_tracker.sv */
// testbench top for the midi note ownership tracker: clock, reset, stimulus and verdict
// depends on mnot_pkg, midi_note_ownership_tracker and tracker_result_checker
`timescale 1ns / 1ps

module tb_midi_note_ownership_tracker;

  localparam logic [1:0] KIND_UNKNOWN   = 2'd3;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         PHASE_WORDS    = 100;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [63:0] cfg_wdata   = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata     = '0;
  logic [2:0]  s_tuser     = '0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  int          mismatches;
  int          outstanding;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;

  midi_note_ownership_tracker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  tracker_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tuser_i   (m_tuser),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one word after random idle cycles; returns at a falling edge with tvalid high
  task automatic send_word(input mnot_pkg::op_e op, input logic [1:0] kind,
                           input logic [3:0] chan,
                           input logic [6:0] note, input logic [6:0] vel,
                           input logic [5:0] src, input logic [9:0] mframe,
                           input logic [9:0] fidx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, fidx, mframe, src, vel, note, chan};
    s_tuser  <= {kind, op};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // hold the sender until every predicted word has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // new accept mask, written only with the block idle
  task automatic write_mask(input logic [63:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // random word; notes and sources mostly from small pools so ownership collides
  task automatic send_random_word();
    mnot_pkg::op_e op;
    logic [1:0]    kind;
    logic [6:0]    note;
    logic [5:0]    src;
    logic [9:0]    fidx;
    logic [9:0]    mframe;
    int            pick;
    op   = $urandom_range(1) ? mnot_pkg::OP_PLAY : mnot_pkg::OP_OFFER;
    pick = $urandom_range(99);
    kind = (pick < 40) ? mnot_pkg::KIND_ON : (pick < 80) ? mnot_pkg::KIND_OFF :
           (pick < 95) ? mnot_pkg::KIND_OTHER : KIND_UNKNOWN;
    note = ($urandom_range(9) < 8) ? 7'(40 + $urandom_range(5)) : 7'($urandom_range(127));
    src  = ($urandom_range(9) < 8) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
    fidx = 10'($urandom_range(1023));
    mframe = ($urandom_range(99) < 85) ? 10'($urandom_range(fidx)) :
                                         10'($urandom_range(1023));
    send_word(op, kind, 4'($urandom_range(15)), note, 7'($urandom_range(127)), src,
              mframe, fidx);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // mask at reset value: only ownership lets note-offs through
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_ON,      0,   0,   0,  5,    0,    0);
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_ON,      0,   0, 127,  5,    0,    0);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_OFF,     0,   0,   0,  5,    0,    0);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_OFF,     0,   0,   0,  6,    0,    0);
    // retrigger of a sounding note, then the same note-on again
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_ON,     15,   0, 100,  6,    0,    0);
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_ON,     15,   0, 100,  6,    0,    0);
    // top note and slot, note-off when sounding and when silent
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_ON,     15, 127,   0, 63, 1023, 1023);
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_OFF,     3, 127,  64, 63, 1022, 1023);
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_OFF,     3, 127,  64, 63, 1022, 1023);
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_OTHER,   7,  64,   1,  0,    0, 1023);
    send_word(mnot_pkg::OP_PLAY,  KIND_UNKNOWN,           8, 127, 127, 63,  512,  512);
    // messages still ahead of the slot are neither played nor consumed
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_ON,      0,   5,   5,  1, 1023,    0);
    send_word(mnot_pkg::OP_PLAY,  mnot_pkg::KIND_OFF,     0,   0,   0,  1,  513,  512);
    send_word(mnot_pkg::OP_OFFER, KIND_UNKNOWN,          15, 127, 127, 63, 1023, 1023);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_ON,      0,   0,   0,  6,    0,    0);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_OFF,     0,   0,   0,  6,    0,    0);

    // every source open, then only the two outer ones
    write_mask('1);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_OTHER,   0,   0,   0, 63,    0,    0);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_ON,      0,   0,   0,  0,    0,    0);
    write_mask(64'h8000_0000_0000_0001);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_ON,      0,   1,   0, 63,    0,    0);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_ON,      0,   1,   0,  1,    0,    0);
    send_word(mnot_pkg::OP_OFFER, mnot_pkg::KIND_ON,      0,   1,   0,  0,    0,    0);

    // random phases, each with its own idling and mask
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_mask('1);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_mask({$urandom, $urandom});
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          write_mask('0);
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          write_mask({$urandom, $urandom});
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 1 && n == PHASE_WORDS / 2) wait_drained();
        send_random_word();
      end
    end

    // drain and give the pipeline time to settle
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/mnot_pkg.sv
sv/mnot_front.sv
sv/mnot_queue.sv
sv/mnot_back.sv
sv/midi_note_ownership_tracker.sv
dv/tracker_result_checker.sv
dv/tb_midi_note_ownership_tracker.sv
